/* sv/jlsl_pkg.sv */
package jlsl_pkg;

  // lean mapping divider: dividend, divisor (remainder) and step counter widths
  localparam int DVD_W = 26;
  localparam int DVS_W = 10;
  localparam int CNT_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  // register reset values
  localparam logic [8:0]  RST_DEADZONE  = 9'd40;
  localparam logic [9:0]  RST_FULL      = 10'd512;
  localparam logic [15:0] RST_MAX_LEAN  = 16'd5120;
  localparam logic [19:0] RST_SLEW_RATE = 20'd10240;
  localparam logic [9:0]  RST_THRESHOLD = 10'd10;

  localparam logic [16:0] DT_CAP_US = 17'd100000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;

  // division length of the lean mapping (26-bit product)
  localparam logic [CNT_W-1:0] TARGET_STEPS = 5'd26;

  // slew step: one million is 64 * 15625; the division by 15625 is a
  // multiplication by ceil(2^45 / 15625), exact for dividends below 2^31
  localparam int SLEW_P_W    = 37;
  localparam int SLEW_PRE_SH = 6;
  localparam int SLEW_X_W    = 31;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SH    = 45;
  localparam int HALF_P_W    = 47;
  localparam int ACC_W       = 63;
  localparam logic [RECIP_W-1:0] RECIP_15625 = 32'd2251799814;

  typedef struct packed {
    logic capture;
    logic load_target;
    logic div_step;
    logic load_slew;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } jlsl_cmd_t;

  typedef struct packed {
    logic div_done;
  } jlsl_status_t;

endpackage

/* sv/jlsl_ctrl.sv */
module jlsl_ctrl
  import jlsl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  jlsl_status_t status,
  output jlsl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD_T = 3'd1;
  localparam logic [2:0] S_RUN_T  = 3'd2;
  localparam logic [2:0] S_LOAD_S = 3'd3;
  localparam logic [2:0] S_MUL_LO = 3'd4;
  localparam logic [2:0] S_MUL_HI = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD_T;
        end
      end
      S_LOAD_T: begin
        cmd.load_target = 1'b1;
        state_next      = S_RUN_T;
      end
      S_RUN_T: begin
        if (status.div_done) state_next = S_LOAD_S;
        else cmd.div_step = 1'b1;
      end
      S_LOAD_S: begin
        cmd.load_slew = 1'b1;
        state_next    = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* sv/jlsl_datapath.sv */
module jlsl_datapath
  import jlsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [10:0]    stick_y,
  input  logic                  connected,
  input  logic                  button_a,
  input  logic [31:0]           elapsed_us,
  input  jlsl_cmd_t             cmd,
  output jlsl_status_t          status,
  output logic signed [16:0]    drive_command,
  output logic                  joystick_active,
  output logic                  emergency_stop
);

  logic [8:0]  deadzone;
  logic [9:0]  full;
  logic [15:0] max_lean;
  logic [19:0] slew_rate;
  logic [9:0]  threshold;

  // latched transaction
  logic        lat_neg;
  logic        lat_active;
  logic        lat_degen;
  logic [9:0]  lat_m;
  logic [16:0] lat_el;
  logic        lat_estop;

  // restoring divider for the lean mapping
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] divisor;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // slew step by reciprocal multiplication, two 16-bit halves
  logic [SLEW_P_W-1:0] prod_s;
  logic [SLEW_X_W-1:0] slew_x;
  logic [HALF_P_W-1:0] part_lo;
  logic [HALF_P_W-1:0] part_hi;
  logic [ACC_W-1:0]    acc;

  logic signed [16:0] target;
  logic signed [16:0] lean_command;

  // capture side
  logic [10:0] mag_in;
  logic        over_dz;
  logic        degen;
  logic [10:0] clamped;
  logic [10:0] m_full;
  logic [16:0] el_sat;

  // target side
  logic [25:0] prod_t;
  logic [9:0]  span;
  logic [15:0] tmag;

  // finish side
  logic [16:0]        step;
  logic signed [17:0] diff_raw;
  logic signed [17:0] step_s;
  logic signed [17:0] diff;
  logic signed [17:0] cmd_sum;
  logic [16:0]        cmd_mag;

  assign mag_in  = stick_y[10] ? 11'(~stick_y + 11'sd1) : stick_y;
  assign over_dz = mag_in > {2'b00, deadzone};
  assign degen   = full <= {1'b0, deadzone};
  assign clamped = (mag_in > {1'b0, full}) ? {1'b0, full} : mag_in;
  assign m_full  = clamped - {2'b00, deadzone};
  assign el_sat  = (elapsed_us > {15'd0, DT_CAP_US}) ? DT_CAP_US : elapsed_us[16:0];

  assign prod_t = 26'(lat_m) * 26'(max_lean);
  assign span   = full - {1'b0, deadzone};
  assign tmag   = !lat_active ? 16'd0 : (lat_degen ? max_lean : dvd[15:0]);

  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  assign status.div_done = (cnt == '0);

  assign prod_s  = SLEW_P_W'(slew_rate) * SLEW_P_W'(lat_el);
  assign part_lo = HALF_P_W'(slew_x) * HALF_P_W'(RECIP_15625[15:0]);
  assign part_hi = HALF_P_W'(slew_x) * HALF_P_W'(RECIP_15625[31:16]);

  assign step     = acc[ACC_W-2:RECIP_SH];
  assign diff_raw = $signed({target[16], target}) - $signed({lean_command[16], lean_command});
  assign step_s   = $signed({1'b0, step});
  always_comb begin
    diff = diff_raw;
    if (diff_raw > step_s) diff = step_s;
    else if (diff_raw < -step_s) diff = -step_s;
  end
  assign cmd_sum = $signed({lean_command[16], lean_command}) + diff;
  assign cmd_mag = cmd_sum[17] ? 17'(-cmd_sum) : cmd_sum[16:0];

  assign drive_command = lean_command;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone  <= RST_DEADZONE;
      full      <= RST_FULL;
      max_lean  <= RST_MAX_LEAN;
      slew_rate <= RST_SLEW_RATE;
      threshold <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADZONE:  deadzone  <= cfg_data[8:0];
        REG_FULL:      full      <= cfg_data[9:0];
        REG_MAX_LEAN:  max_lean  <= cfg_data[15:0];
        REG_SLEW_RATE: slew_rate <= cfg_data[19:0];
        REG_THRESHOLD: threshold <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // control-relevant state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      lean_command <= '0;
    end else begin
      if (cmd.load_target) cnt <= TARGET_STEPS;
      else if (cmd.div_step) cnt <= cnt - 1'b1;
      if (cmd.finish) lean_command <= cmd_sum[16:0];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat_neg    <= stick_y[10];
      lat_active <= connected && over_dz;
      lat_degen  <= degen;
      lat_m      <= m_full[9:0];
      lat_el     <= el_sat;
      lat_estop  <= connected && button_a;
    end
    if (cmd.load_target) begin
      dvd     <= prod_t;
      divisor <= span;
      rem     <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], fits};
    end
    if (cmd.load_slew) begin
      // drop the factor 64 of one million exactly
      slew_x <= prod_s[SLEW_P_W-1:SLEW_PRE_SH];
      target <= lat_neg ? $signed({1'b0, tmag}) : -$signed({1'b0, tmag});
    end
    if (cmd.mul_lo) acc <= ACC_W'(part_lo);
    else if (cmd.mul_hi) acc <= acc + {part_hi, 16'd0};
    if (cmd.finish) begin
      joystick_active <= lat_active || (cmd_mag > {7'd0, threshold});
      emergency_stop  <= lat_estop;
    end
  end

endmodule

/* sv/joystick_lean_slew_limiter.sv */
// joystick lean slew limiter: each input transaction carries a signed stick
// sample, a connected flag, the emergency button and the elapsed time in us.
// the stick magnitude beyond the deadzone is clamped to stick_full and mapped
// linearly onto 0..max_lean (forward stick gives positive lean), then the
// kept drive command moves toward that target by at most
// floor(slew_rate * min(elapsed_us, 100000) / 1000000). exactly one output
// transaction follows each input transaction. after acceptance the lean
// mapping runs one quotient bit per cycle through a 26-step restoring
// divider, then the slew step divides by one million as a shift by six and
// a reciprocal multiplication done in two halves, low then high, and the
// result is committed to the output register once that register is free.
// one item is worked on at a time; the next input is taken once the result
// sits in the output register, even if it has not been taken yet.
// configuration registers are written through cfg_we/cfg_index/cfg_data
// (index 0 deadzone, 1 stick_full, 2 max_lean, 3 slew_rate, 4 threshold);
// the user must write them only while the block is idle, which the block
// itself does not enforce; there is no read-back.
module joystick_lean_slew_limiter
  import jlsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [10:0]    stick_y,
  input  logic                  connected,
  input  logic                  button_a,
  input  logic [31:0]           elapsed_us,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [16:0]    drive_command,
  output logic                  joystick_active,
  output logic                  emergency_stop
);

  // command and status between sequencer and datapath
  jlsl_cmd_t    cmd;
  jlsl_status_t status;

  // sequencer: accepts a transaction, runs the mapping division and the
  // slew multiply, commits the result
  jlsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config registers, mapping, divider, slew step and clamp, outputs
  jlsl_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .stick_y         (stick_y),
    .connected       (connected),
    .button_a        (button_a),
    .elapsed_us      (elapsed_us),
    .cmd             (cmd),
    .status          (status),
    .drive_command   (drive_command),
    .joystick_active (joystick_active),
    .emergency_stop  (emergency_stop)
  );

endmodule
